>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked property checks on clk with rst_n as the disable condition
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/lgsh_pkg.sv
// ---------------------------------------------------------------------------
// lgsh_pkg
// types, constants and hash helpers for the lower-casing glob-aware hash
// ---------------------------------------------------------------------------
package lgsh_pkg;

    localparam int CHAR_W = 8;
    localparam int HASH_W = 32;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [HASH_W-1:0] hash_t;

    // configuration reset value: asterisk
    localparam char_t GLOB_RESET = 8'd42;

    localparam char_t NUL_CHAR = 8'h00;
    localparam char_t UPPER_A  = 8'h41;
    localparam char_t UPPER_Z  = 8'h5A;
    localparam char_t CASE_OFS = 8'h20;

    // one-at-a-time shift amounts
    localparam int MIX_SHL  = 10;
    localparam int MIX_SHR  = 6;
    localparam int FIN_SHL1 = 3;
    localparam int FIN_SHR  = 11;
    localparam int FIN_SHL2 = 15;

    // payload handed from the mixing stage to the finishing stage
    typedef struct packed {
        char_t norm_char;
        logic  done;
        logic  glob;
        hash_t pre_hash;
        hash_t len;
    } lgsh_stage_t;

    // ascii upper case to lower case, everything else unchanged
    function automatic char_t lower_char(char_t c);
        char_t r;
        r = c;
        if (c inside {[UPPER_A:UPPER_Z]})
            r = c + CASE_OFS;
        return r;
    endfunction

    // per-byte mixing step
    function automatic hash_t mix_byte(hash_t h, char_t b);
        hash_t t;
        t = h + {{(HASH_W-CHAR_W){1'b0}}, b};
        t = t + (t << MIX_SHL);
        t = t ^ (t >> MIX_SHR);
        return t;
    endfunction

    // finalising shifts, length already added
    function automatic hash_t finish_core(hash_t h);
        hash_t t;
        t = h + (h << FIN_SHL1);
        t = t ^ (t >> FIN_SHR);
        t = t + (t << FIN_SHL2);
        return t;
    endfunction

endpackage

>>> rtl/lgsh_char_if.sv
// ---------------------------------------------------------------------------
// lgsh_char_if
// byte input channel: one string byte per transfer
// ---------------------------------------------------------------------------
interface lgsh_char_if
    import lgsh_pkg::*;
;
    logic  valid;
    logic  ready;
    char_t char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

>>> rtl/lgsh_res_if.sv
// ---------------------------------------------------------------------------
// lgsh_res_if
// result channel: normalised byte, end of string, hash and glob flag
// ---------------------------------------------------------------------------
interface lgsh_res_if
    import lgsh_pkg::*;
;
    logic  valid;
    logic  ready;
    char_t norm_char;
    logic  string_done;
    hash_t hash_out;
    logic  glob_seen;

    modport source (output valid, output norm_char, output string_done,
                    output hash_out, output glob_seen, input ready);
    modport sink (input valid, input norm_char, input string_done,
                  input hash_out, input glob_seen, output ready);
endinterface

>>> rtl/lgsh_cfg_if.sv
// ---------------------------------------------------------------------------
// lgsh_cfg_if
// configuration write channel for the glob character register
// ---------------------------------------------------------------------------
interface lgsh_cfg_if
    import lgsh_pkg::*;
;
    logic  valid;
    logic  ready;
    char_t glob_char;

    modport source (output valid, output glob_char, input ready);
    modport sink (input valid, input glob_char, output ready);
endinterface

>>> rtl/lgsh_mix.sv
// ---------------------------------------------------------------------------
// lgsh_mix
// running hash state: lowers each non-glob byte, mixes it in, tracks length and glob
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lgsh_mix
    import lgsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  char_t       in_char,
    input  char_t       glob_char,
    output logic        in_ready,
    output logic        out_valid,
    output lgsh_stage_t out_stage,
    input  logic        out_ready
);

    hash_t       hash_reg, hash_next;
    hash_t       count_reg, count_next;
    logic        glob_reg, glob_next;
    logic        valid_reg;
    lgsh_stage_t stage_reg, stage_next;
    logic        adv;
    logic        is_zero;
    logic        is_glob;
    char_t       norm;

    // stage handshake
    assign in_ready = !valid_reg || out_ready;
    assign adv      = in_valid && in_ready;

    // byte classification, glob compared before lowering
    assign is_zero = (in_char == NUL_CHAR);
    assign is_glob = !is_zero && (in_char == glob_char);
    assign norm    = is_glob ? in_char : lower_char(in_char);

    // next running state
    always_comb
    begin
        if (is_zero)
        begin
            hash_next  = '0;
            count_next = '0;
            glob_next  = 1'b0;
        end
        else
        begin
            count_next = count_reg + hash_t'(1);
            glob_next  = glob_reg || is_glob;
            if (is_glob || glob_reg)
                hash_next = '0;
            else
                hash_next = mix_byte(hash_reg, norm);
        end
    end

    // payload to the finishing stage
    always_comb
    begin
        stage_next.norm_char = norm;
        stage_next.done      = is_zero;
        stage_next.glob      = glob_reg;
        stage_next.pre_hash  = hash_reg + count_reg;
        stage_next.len       = count_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= '0;
            count_reg <= '0;
            glob_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                hash_reg  <= hash_next;
                count_reg <= count_next;
                glob_reg  <= glob_next;
            end
            if (in_ready)
                valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
            stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

    // checks
    `ASSERT_CHK(a_clear_on_end, (adv && is_zero) |=> (hash_reg == '0 && count_reg == '0 && !glob_reg), "state not cleared after end of string")
    `ASSERT_CHK(a_count_step, (adv && !is_zero) |=> (count_reg == $past(count_reg) + 32'd1), "length did not step by one")
    `ASSERT_NEVER(a_glob_hash, glob_reg && (hash_reg != '0), "hash kept running after glob byte")

endmodule

>>> rtl/lgsh_fin.sv
// ---------------------------------------------------------------------------
// lgsh_fin
// finalising shifts, zero-hash substitution and result register
// ---------------------------------------------------------------------------
module lgsh_fin
    import lgsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  lgsh_stage_t in_stage,
    output logic        in_ready,
    lgsh_res_if.source  res
);

    logic  valid_reg;
    char_t norm_reg;
    logic  done_reg;
    hash_t hash_reg, hash_next;
    logic  glob_reg;
    hash_t fin_hash;
    logic  adv;

    assign in_ready = !valid_reg || res.ready;
    assign adv      = in_valid && in_ready;

    // finalise, a zero hash becomes one plus the length
    always_comb
    begin
        fin_hash = finish_core(in_stage.pre_hash);
        if (fin_hash == '0)
            fin_hash = in_stage.len + hash_t'(1);
        hash_next = (in_stage.done && !in_stage.glob) ? fin_hash : '0;
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            norm_reg <= in_stage.norm_char;
            done_reg <= in_stage.done;
            hash_reg <= hash_next;
            glob_reg <= in_stage.done && in_stage.glob;
        end
    end

    assign res.valid       = valid_reg;
    assign res.norm_char   = norm_reg;
    assign res.string_done = done_reg;
    assign res.hash_out    = hash_reg;
    assign res.glob_seen   = glob_reg;

endmodule

>>> rtl/lowercase_glob_aware_string_hash.sv
// ---------------------------------------------------------------------------
// lowercase_glob_aware_string_hash
// lower-casing one-at-a-time string hash with glob detection, top level
// ---------------------------------------------------------------------------
// datapath: each byte passes the input, mixing and result registers before its
//   result is shown on the result channel
// throughput: one byte per cycle while the result channel is ready, set by the
//   per-byte mix loop on the running hash register
// reset: rst_n clears all valids and the running state, glob character to 42
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lowercase_glob_aware_string_hash
    import lgsh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lgsh_char_if.sink  char_ch,
    lgsh_res_if.source res_ch,
    lgsh_cfg_if.sink   cfg
);

    char_t       glob_char_reg;
    logic        in_valid_reg;
    char_t       in_char_reg;
    logic        mix_ready;
    logic        mix_valid;
    lgsh_stage_t mix_stage;
    logic        fin_ready;

    // configuration register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            glob_char_reg <= GLOB_RESET;
        else if (cfg.valid)
            glob_char_reg <= cfg.glob_char;
    end

    // input register
    assign char_ch.ready = !in_valid_reg || mix_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (char_ch.ready)
            in_valid_reg <= char_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_ch.valid && char_ch.ready)
            in_char_reg <= char_ch.char_in;
    end

    // running hash stage
    lgsh_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_char   (in_char_reg),
        .glob_char (glob_char_reg),
        .in_ready  (mix_ready),
        .out_valid (mix_valid),
        .out_stage (mix_stage),
        .out_ready (fin_ready)
    );

    // finishing stage and result register
    lgsh_fin u_fin (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mix_valid),
        .in_stage (mix_stage),
        .in_ready (fin_ready),
        .res      (res_ch)
    );

    // checks
    `ASSERT_CHK(a_done_nul,
        (res_ch.valid && res_ch.string_done) |-> (res_ch.norm_char == NUL_CHAR),
        "end of string result with non-zero byte")
    `ASSERT_CHK(a_mid_quiet,
        (res_ch.valid && !res_ch.string_done) |-> (res_ch.hash_out == '0 && !res_ch.glob_seen),
        "hash or glob shown before end of string")
    `ASSERT_CHK(a_glob_zero,
        (res_ch.valid && res_ch.glob_seen) |-> (res_ch.hash_out == '0),
        "glob pattern with non-zero hash")

endmodule
